### sv/mra_pkg.sv
// mra_pkg: shared widths, command codes and defaults for the register alu
// no dependencies
package mra_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned CmdW        = 4;
  localparam int unsigned RegCountDef = 32;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD32 = 4'd0,
    CMD_ADD64 = 4'd1,
    CMD_SUB32 = 4'd2,
    CMD_SUB64 = 4'd3,
    CMD_AND   = 4'd4,
    CMD_OR    = 4'd5,
    CMD_XOR   = 4'd6,
    CMD_NOR   = 4'd7,
    CMD_SLT   = 4'd8,
    CMD_SLTU  = 4'd9,
    CMD_LOAD  = 4'd10
  } cmd_e;

endpackage

### sv/mra_if.sv
// mra_if: valid/ready channel interfaces for alu commands and results
// depends on mra_pkg
interface mra_in_if;
  logic                      valid;
  logic                      ready;
  logic [mra_pkg::CmdW-1:0]  command;
  logic [mra_pkg::IdxW-1:0]  source_a_index;
  logic [mra_pkg::IdxW-1:0]  source_b_index;
  logic [mra_pkg::IdxW-1:0]  dest_index;
  logic [mra_pkg::DataW-1:0] load_value;

  modport source (output valid, command, source_a_index, source_b_index, dest_index,
                  load_value, input ready);
  modport sink (input valid, command, source_a_index, source_b_index, dest_index,
                load_value, output ready);
endinterface

interface mra_out_if;
  logic                      valid;
  logic                      ready;
  logic [mra_pkg::DataW-1:0] result_value;
  logic [mra_pkg::IdxW-1:0]  result_dest;
  logic                      wrote;

  modport source (output valid, result_value, result_dest, wrote, input ready);
  modport sink (input valid, result_value, result_dest, wrote, output ready);
endinterface

### sv/mra_ram.sv
// mra_ram: generic ram, one write port, two registered read ports
// no dependencies
module mra_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 32,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_a_i,
  input  logic [AddrW-1:0] raddr_b_i,
  output logic [Width-1:0] rdata_a_o,
  output logic [Width-1:0] rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem_q[raddr_a_i];
      rdata_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### sv/mra_alu.sv
// mra_alu: combinational 64-bit integer operation on two operands
// depends on mra_pkg
module mra_alu (
  input  mra_pkg::cmd_e             cmd_i,
  input  logic [mra_pkg::DataW-1:0] op_a_i,
  input  logic [mra_pkg::DataW-1:0] op_b_i,
  input  logic [mra_pkg::DataW-1:0] load_value_i,
  output logic [mra_pkg::DataW-1:0] value_o,
  output logic                      known_o
);
  import mra_pkg::*;

  logic [DataW-1:0] sum;
  logic [DataW-1:0] diff;
  logic             lt_s;
  logic             lt_u;

  assign sum  = op_a_i + op_b_i;
  assign diff = op_a_i - op_b_i;
  assign lt_u = op_a_i < op_b_i;
  assign lt_s = $signed(op_a_i) < $signed(op_b_i);

  always_comb begin
    value_o = '0;
    known_o = 1'b1;
    unique case (cmd_i)
      CMD_ADD32: value_o = {{(DataW-32){sum[31]}}, sum[31:0]};
      CMD_ADD64: value_o = sum;
      CMD_SUB32: value_o = {{(DataW-32){diff[31]}}, diff[31:0]};
      CMD_SUB64: value_o = diff;
      CMD_AND:   value_o = op_a_i & op_b_i;
      CMD_OR:    value_o = op_a_i | op_b_i;
      CMD_XOR:   value_o = op_a_i ^ op_b_i;
      CMD_NOR:   value_o = ~(op_a_i | op_b_i);
      CMD_SLT:   value_o = {{(DataW-1){1'b0}}, lt_s};
      CMD_SLTU:  value_o = {{(DataW-1){1'b0}}, lt_u};
      CMD_LOAD:  value_o = load_value_i;
      default:   known_o = 1'b0;
    endcase
  end

endmodule

### sv/mips64_register_alu.sv
// Register-register integer alu with a RegCount x 64-bit register file. One
// transaction is accepted every cycle unless the operand stage is full and the
// output register holds a stalled result. On its way to the output, the
// register file read ports are registered, then the operation result is
// registered at the output. A result that writes a register is forwarded to
// the transaction read in the same cycle, so back-to-back dependent commands
// see the new value. Register 0 and indexes at or above RegCount read as
// zero and are never written. Reset clears the register file at once through
// a valid bit for each entry, so no clearing pass is needed.
// depends on mra_pkg, mra_if, mra_ram, mra_alu
module mips64_register_alu #(
  parameter int unsigned RegCount = mra_pkg::RegCountDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mra_in_if.sink    alu_in_i,
  mra_out_if.source alu_out_o
);
  import mra_pkg::*;

  localparam int unsigned AddrW = (RegCount > 1) ? $clog2(RegCount) : 1;

  function automatic logic idx_in_range(input logic [IdxW-1:0] idx);
    return {{(32-IdxW){1'b0}}, idx} < 32'(RegCount);
  endfunction

  logic             in_accept;
  logic             out_free;
  logic             s1_adv;

  logic             s1_vld_q;
  cmd_e             s1_cmd_q;
  logic [IdxW-1:0]  s1_dest_q;
  logic [DataW-1:0] s1_load_q;
  logic             fwd_a_q;
  logic             fwd_b_q;
  logic             vld_a_q;
  logic             vld_b_q;
  logic [DataW-1:0] fwd_val_q;

  logic [RegCount-1:0] valid_q;

  logic             out_vld_q;
  logic [DataW-1:0] out_value_q;
  logic [IdxW-1:0]  out_dest_q;
  logic             out_wrote_q;

  logic [DataW-1:0] rdata_a;
  logic [DataW-1:0] rdata_b;
  logic [DataW-1:0] op_a;
  logic [DataW-1:0] op_b;
  logic [DataW-1:0] alu_val;
  logic             alu_known;
  logic             ram_we;
  logic             vld_a_d;
  logic             vld_b_d;

  assign out_free       = !out_vld_q || alu_out_o.ready;
  assign s1_adv         = s1_vld_q && out_free;
  assign alu_in_i.ready = !s1_vld_q || out_free;
  assign in_accept      = alu_in_i.valid && alu_in_i.ready;

  assign ram_we = s1_adv && alu_known && (s1_dest_q != '0) && idx_in_range(s1_dest_q);

  mra_ram #(
    .Width(DataW),
    .Depth(RegCount)
  ) u_regfile (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (s1_dest_q[AddrW-1:0]),
    .wdata_i  (alu_val),
    .re_i     (in_accept),
    .raddr_a_i(alu_in_i.source_a_index[AddrW-1:0]),
    .raddr_b_i(alu_in_i.source_b_index[AddrW-1:0]),
    .rdata_a_o(rdata_a),
    .rdata_b_o(rdata_b)
  );

  assign vld_a_d = idx_in_range(alu_in_i.source_a_index)
                   && valid_q[alu_in_i.source_a_index[AddrW-1:0]];
  assign vld_b_d = idx_in_range(alu_in_i.source_b_index)
                   && valid_q[alu_in_i.source_b_index[AddrW-1:0]];

  assign op_a = fwd_a_q ? fwd_val_q : (vld_a_q ? rdata_a : '0);
  assign op_b = fwd_b_q ? fwd_val_q : (vld_b_q ? rdata_b : '0);

  mra_alu u_alu (
    .cmd_i       (s1_cmd_q),
    .op_a_i      (op_a),
    .op_b_i      (op_b),
    .load_value_i(s1_load_q),
    .value_o     (alu_val),
    .known_o     (alu_known)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      if (alu_in_i.ready) begin
        s1_vld_q <= alu_in_i.valid;
      end
      if (out_free) begin
        out_vld_q <= s1_vld_q;
      end
      if (ram_we) begin
        valid_q[s1_dest_q[AddrW-1:0]] <= 1'b1;
      end
    end
  end

  // operand stage payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q  <= cmd_e'(alu_in_i.command);
      s1_dest_q <= alu_in_i.dest_index;
      s1_load_q <= alu_in_i.load_value;
      vld_a_q   <= vld_a_d;
      vld_b_q   <= vld_b_d;
      fwd_a_q   <= ram_we && (s1_dest_q == alu_in_i.source_a_index);
      fwd_b_q   <= ram_we && (s1_dest_q == alu_in_i.source_b_index);
      fwd_val_q <= alu_val;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= alu_val;
      out_dest_q  <= s1_dest_q;
      out_wrote_q <= ram_we;
    end
  end

  assign alu_out_o.valid        = out_vld_q;
  assign alu_out_o.result_value = out_value_q;
  assign alu_out_o.result_dest  = out_dest_q;
  assign alu_out_o.wrote        = out_wrote_q;

endmodule

### verif/mips64_register_alu_tb.sv
// self-checking testbench for mips64_register_alu: directed and random alu commands
// predicted against a shadow register file; depends on mra_pkg, mra_if, mips64_register_alu
`timescale 1ns / 1ps

module mips64_register_alu_tb;
  import mra_pkg::*;

  localparam int unsigned RegCount      = RegCountDef;
  localparam int unsigned RandomPerPhase = 120;
  localparam int unsigned PhaseCount    = 4;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 8;
  localparam logic [CmdW-1:0] CmdFirstUnused = CmdW'(CMD_LOAD + 1);
  localparam logic [CmdW-1:0] CmdLastUnused  = '1;

  typedef struct packed {
    logic [CmdW-1:0]  command;
    logic [IdxW-1:0]  src_a;
    logic [IdxW-1:0]  src_b;
    logic [IdxW-1:0]  dest;
    logic [DataW-1:0] load_value;
  } alu_cmd_t;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic [IdxW-1:0]  dest;
    logic             wrote;
  } alu_result_t;

  logic clk_i;
  logic rst_ni;

  mra_in_if  alu_in ();
  mra_out_if alu_out ();

  mips64_register_alu i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .alu_in_i  (alu_in),
    .alu_out_o (alu_out)
  );

  alu_cmd_t    pending_cmds_q[$];
  alu_result_t expected_results_q[$];
  logic [DataW-1:0] shadow_regs[RegCount];

  int unsigned send_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned queued_count;
  int unsigned accepted_count;
  int unsigned checked_count;
  int unsigned dropped_writes;
  int unsigned error_count;
  int unsigned idle_cycles;
  int unsigned cmd_hits[16];
  logic        in_taken;

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  function automatic alu_result_t execute_alu_command(input alu_cmd_t c);
    logic [DataW-1:0] a;
    logic [DataW-1:0] b;
    logic [DataW-1:0] sum;
    logic             known;
    alu_result_t      r;
    a = (c.src_a == 0 || c.src_a >= RegCount) ? '0 : shadow_regs[c.src_a];
    b = (c.src_b == 0 || c.src_b >= RegCount) ? '0 : shadow_regs[c.src_b];
    known = 1'b1;
    r.value = '0;
    case (cmd_e'(c.command))
      CMD_ADD32: begin
        sum = a + b;
        r.value = {{32{sum[31]}}, sum[31:0]};
      end
      CMD_ADD64: r.value = a + b;
      CMD_SUB32: begin
        sum = a - b;
        r.value = {{32{sum[31]}}, sum[31:0]};
      end
      CMD_SUB64: r.value = a - b;
      CMD_AND:   r.value = a & b;
      CMD_OR:    r.value = a | b;
      CMD_XOR:   r.value = a ^ b;
      CMD_NOR:   r.value = ~(a | b);
      CMD_SLT:   r.value = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
      CMD_SLTU:  r.value = (a < b) ? 64'd1 : 64'd0;
      CMD_LOAD:  r.value = c.load_value;
      default:   known = 1'b0;
    endcase
    r.dest  = c.dest;
    r.wrote = known && c.dest != 0 && c.dest < RegCount;
    if (r.wrote) begin
      shadow_regs[c.dest] = r.value;
    end
    return r;
  endfunction

  function automatic alu_cmd_t make_cmd(input logic [CmdW-1:0] cmd, input logic [IdxW-1:0] a,
                                        input logic [IdxW-1:0] b, input logic [IdxW-1:0] d,
                                        input logic [DataW-1:0] v);
    alu_cmd_t c;
    c.command    = cmd;
    c.src_a      = a;
    c.src_b      = b;
    c.dest       = d;
    c.load_value = v;
    return c;
  endfunction

  function automatic logic [IdxW-1:0] random_index();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      return '0;
    end else if (roll < 60) begin
      return IdxW'($urandom_range(7, 1));
    end
    return IdxW'($urandom_range(RegCount - 1));
  endfunction

  function automatic alu_cmd_t random_cmd();
    alu_cmd_t    c;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 18) begin
      c.command = CMD_LOAD;
    end else if (roll < 23) begin
      c.command = CmdW'($urandom_range(CmdLastUnused, CmdFirstUnused));
    end else begin
      c.command = CmdW'($urandom_range(CMD_SLTU, CMD_ADD32));
    end
    c.src_a = random_index();
    c.src_b = random_index();
    c.dest  = random_index();
    case ($urandom_range(9))
      0: c.load_value = '1;
      1: c.load_value = 64'h8000_0000_0000_0000;
      2: c.load_value = 64'h0000_0000_7fff_ffff;
      3: c.load_value = 64'h0000_0000_8000_0000;
      4: c.load_value = 64'd1;
      default: c.load_value = {$urandom, $urandom};
    endcase
    return c;
  endfunction

  function automatic int unsigned checked_alu_hits();
    int unsigned total;
    total = 0;
    for (int i = CMD_ADD32; i <= CMD_SLTU; i++) begin
      total += cmd_hits[i];
    end
    return total;
  endfunction

  task automatic queue_cmd(input alu_cmd_t c);
    pending_cmds_q.push_back(c);
    queued_count++;
  endtask

  // driver: hold the payload until the transaction is taken
  always @(negedge clk_i) begin
    alu_cmd_t nxt;
    if (rst_ni) begin
      if (!alu_in.valid || in_taken) begin
        if (pending_cmds_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_cmds_q.pop_front();
          alu_in.valid          <= 1'b1;
          alu_in.command        <= nxt.command;
          alu_in.source_a_index <= nxt.src_a;
          alu_in.source_b_index <= nxt.src_b;
          alu_in.dest_index     <= nxt.dest;
          alu_in.load_value     <= nxt.load_value;
        end else begin
          alu_in.valid <= 1'b0;
        end
      end
      alu_out.ready <= $urandom_range(99) >= sink_stall_pct;
    end
  end

  // monitor: predict on input transactions, check output transactions
  always @(posedge clk_i) begin
    alu_cmd_t    c;
    alu_result_t exp_r;
    in_taken = alu_in.valid && alu_in.ready;
    if (rst_ni) begin
      if (in_taken) begin
        c = make_cmd(alu_in.command, alu_in.source_a_index, alu_in.source_b_index,
                     alu_in.dest_index, alu_in.load_value);
        exp_r = execute_alu_command(c);
        expected_results_q.push_back(exp_r);
        accepted_count++;
        cmd_hits[c.command]++;
        if (!exp_r.wrote && c.dest == 0) begin
          dropped_writes++;
        end
      end
      if (alu_out.valid && alu_out.ready) begin
        if (expected_results_q.size() == 0) begin
          $error("unexpected result: result_value %h result_dest %0d wrote %0b",
                 alu_out.result_value, alu_out.result_dest, alu_out.wrote);
          error_count++;
        end else begin
          exp_r = expected_results_q.pop_front();
          checked_count++;
          if (alu_out.result_value !== exp_r.value) begin
            $error("result_value expected %h actual %h", exp_r.value, alu_out.result_value);
            error_count++;
          end
          if (alu_out.result_dest !== exp_r.dest) begin
            $error("result_dest expected %0d actual %0d", exp_r.dest, alu_out.result_dest);
            error_count++;
          end
          if (alu_out.wrote !== exp_r.wrote) begin
            $error("wrote expected %0b actual %0b", exp_r.wrote, alu_out.wrote);
            error_count++;
          end
        end
      end
      if (in_taken || (alu_out.valid && alu_out.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("timeout: no transaction in %0d cycles", WatchdogLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int unsigned idle_pcts[PhaseCount];
    int unsigned stall_pcts[PhaseCount];
    idle_pcts  = '{0, 79, 0, 24};
    stall_pcts = '{0, 0, 79, 24};
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    queued_count   = 0;
    accepted_count = 0;
    checked_count  = 0;
    dropped_writes = 0;
    error_count    = 0;
    idle_cycles    = 0;
    in_taken       = 1'b0;
    foreach (cmd_hits[i]) cmd_hits[i] = 0;
    foreach (shadow_regs[i]) shadow_regs[i] = '0;
    alu_in.valid          = 1'b0;
    alu_in.command        = '0;
    alu_in.source_a_index = '0;
    alu_in.source_b_index = '0;
    alu_in.dest_index     = '0;
    alu_in.load_value     = '0;
    alu_out.ready         = 1'b0;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // operand extremes, every operation, dest zero, rd equal to rs, dependent chain
    queue_cmd(make_cmd(CMD_LOAD,  5'd0, 5'd0, 5'd1, '1));
    queue_cmd(make_cmd(CMD_LOAD,  5'd0, 5'd0, 5'd2, 64'h8000_0000_0000_0000));
    queue_cmd(make_cmd(CMD_LOAD,  5'd0, 5'd0, 5'd3, 64'h0000_0000_7fff_ffff));
    queue_cmd(make_cmd(CMD_LOAD,  5'd0, 5'd0, 5'd4, 64'd1));
    queue_cmd(make_cmd(CMD_LOAD,  5'd0, 5'd0, 5'd0, 64'hdead_beef_0123_4567));
    queue_cmd(make_cmd(CMD_ADD32, 5'd3, 5'd4, 5'd5, '0));
    queue_cmd(make_cmd(CMD_ADD64, 5'd1, 5'd4, 5'd6, '0));
    queue_cmd(make_cmd(CMD_SUB32, 5'd0, 5'd4, 5'd7, '0));
    queue_cmd(make_cmd(CMD_SUB64, 5'd2, 5'd4, 5'd8, '0));
    queue_cmd(make_cmd(CMD_AND,   5'd1, 5'd2, 5'd9, '0));
    queue_cmd(make_cmd(CMD_OR,    5'd3, 5'd2, 5'd10, '0));
    queue_cmd(make_cmd(CMD_XOR,   5'd1, 5'd3, 5'd11, '0));
    queue_cmd(make_cmd(CMD_NOR,   5'd0, 5'd0, 5'd12, '0));
    queue_cmd(make_cmd(CMD_SLT,   5'd2, 5'd4, 5'd13, '0));
    queue_cmd(make_cmd(CMD_SLTU,  5'd2, 5'd4, 5'd14, '0));
    queue_cmd(make_cmd(CMD_SLT,   5'd1, 5'd1, 5'd15, '0));
    queue_cmd(make_cmd(CMD_ADD64, 5'd5, 5'd5, 5'd5, '0));
    queue_cmd(make_cmd(CMD_SUB64, 5'd5, 5'd6, 5'd5, '0));
    queue_cmd(make_cmd(CmdFirstUnused, 5'd1, 5'd2, 5'd16, '1));
    queue_cmd(make_cmd(CmdLastUnused, 5'd1, 5'd1, 5'd17, '1));
    queue_cmd(make_cmd(CMD_LOAD,  5'd0, 5'd0, 5'd31, '0));
    queue_cmd(make_cmd(CMD_ADD32, 5'd1, 5'd1, 5'd0, '0));
    queue_cmd(make_cmd(CMD_SLTU,  5'd0, 5'd1, 5'd31, '0));

    for (int p = 0; p < PhaseCount; p++) begin
      send_idle_pct  = idle_pcts[p];
      sink_stall_pct = stall_pcts[p];
      for (int n = 0; n < RandomPerPhase; n++) begin
        queue_cmd(random_cmd());
      end
      while (accepted_count != queued_count || expected_results_q.size() != 0) begin
        @(posedge clk_i);
      end
    end

    sink_stall_pct = 0;
    repeat (DrainCycles) @(posedge clk_i);
    $display("ran %0d commands (%0d loads, %0d unused codes, %0d to r0) in %0d idling phases",
             accepted_count, cmd_hits[CMD_LOAD],
             accepted_count - cmd_hits[CMD_LOAD] - checked_alu_hits(), dropped_writes,
             PhaseCount);
    $display("checked %0d results field by field, %0d mismatches", checked_count, error_count);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
sv/mra_pkg.sv
sv/mra_if.sv
sv/mra_ram.sv
sv/mra_alu.sv
sv/mips64_register_alu.sv
verif/mips64_register_alu_tb.sv
